### src/dsa_pkg.sv
// Package for the differential sine/cosine to angle converter.
// Holds the sizing constants, the arctangent table and the pipeline stage type.
`default_nettype none

package dsa_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int ANGLE_BITS    = 16;
  localparam int CORDIC_STAGES = 16;

  localparam int CODE_W      = 16;
  localparam int ANGLE_OUT_W = 16;
  localparam int GUARD_BITS  = 24;
  localparam int ATAN_ENTRIES = 24;
  localparam int Z_W          = 32;

  // Rotation stages actually built: the table limits the count.
  localparam int STAGE_COUNT = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;
  localparam int SHIFT_W     = $clog2(ATAN_ENTRIES);

  // Differences are SAMPLE_BITS+1 wide; the CORDIC gain and the diagonal
  // need two more integer bits, and the guard bits sit below.
  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam int DATA_W = SAMPLE_BITS + 3 + GUARD_BITS;

  localparam logic [Z_W-1:0] HALF_TURN = Z_W'(64'h8000_0000);
  localparam logic [Z_W-1:0] ROUND_ADD = Z_W'(64'd1 << (31 - ANGLE_BITS));

  // atan(2^-i) in units of 2^-32 turn, rounded to nearest.
  localparam logic [Z_W-1:0] ATAN_TURN [ATAN_ENTRIES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic [Z_W-1:0]           z;
    logic                     zero;
  } dsa_stage_t;

endpackage

`default_nettype wire

### src/dsa_if.sv
// Channel interfaces of the converter: sample sets in, angles out.
// Depends on dsa_pkg for the field widths.
`default_nettype none

interface dsa_in_if import dsa_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [CODE_W-1:0] code_ch0;
  logic signed [CODE_W-1:0] code_ch1;
  logic signed [CODE_W-1:0] code_ch2;
  logic signed [CODE_W-1:0] code_ch3;

  modport source (output valid, output code_ch0, output code_ch1, output code_ch2,
                  output code_ch3, input ready);
  modport sink (input valid, input code_ch0, input code_ch1, input code_ch2,
                input code_ch3, output ready);
endinterface

interface dsa_out_if import dsa_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [ANGLE_OUT_W-1:0] angle_turn;
  logic                   zero_field;

  modport source (output valid, output angle_turn, output zero_field, input ready);
  modport sink (input valid, input angle_turn, input zero_field, output ready);
endinterface

`default_nettype wire

### src/dsa_pre.sv
// Front stage: forms the two differences, flags the zero vector and folds
// the vector into the right half plane. Depends on dsa_pkg and dsa_in_if.
`default_nettype none

module dsa_pre import dsa_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  dsa_in_if.sink       sample,
  output logic         dn_valid,
  input  logic         dn_ready,
  output dsa_stage_t   dn_data
);

  logic signed [SAMPLE_BITS-1:0] c0, c1, c2, c3;
  logic signed [DIFF_W-1:0]      x_diff, y_diff;
  logic signed [DATA_W-1:0]      x_wide, y_wide;
  dsa_stage_t                    stage_next;
  logic                          load;

  generate
    if (SAMPLE_BITS <= CODE_W) begin : g_narrow
      assign c0 = sample.code_ch0[SAMPLE_BITS-1:0];
      assign c1 = sample.code_ch1[SAMPLE_BITS-1:0];
      assign c2 = sample.code_ch2[SAMPLE_BITS-1:0];
      assign c3 = sample.code_ch3[SAMPLE_BITS-1:0];
    end else begin : g_wide
      assign c0 = {{(SAMPLE_BITS-CODE_W){1'b0}}, sample.code_ch0};
      assign c1 = {{(SAMPLE_BITS-CODE_W){1'b0}}, sample.code_ch1};
      assign c2 = {{(SAMPLE_BITS-CODE_W){1'b0}}, sample.code_ch2};
      assign c3 = {{(SAMPLE_BITS-CODE_W){1'b0}}, sample.code_ch3};
    end
  endgenerate

  assign sample.ready = !dn_valid || dn_ready;
  assign load         = sample.valid && sample.ready;

  always_comb begin
    y_diff = {c0[SAMPLE_BITS-1], c0} - {c3[SAMPLE_BITS-1], c3};
    x_diff = {c1[SAMPLE_BITS-1], c1} - {c2[SAMPLE_BITS-1], c2};
    x_wide = {{(DATA_W-DIFF_W-GUARD_BITS){x_diff[DIFF_W-1]}}, x_diff, {GUARD_BITS{1'b0}}};
    y_wide = {{(DATA_W-DIFF_W-GUARD_BITS){y_diff[DIFF_W-1]}}, y_diff, {GUARD_BITS{1'b0}}};
    stage_next.zero = (x_diff == '0) && (y_diff == '0);
    // A vector in the left half plane is turned by half a turn.
    if (x_diff[DIFF_W-1]) begin
      stage_next.x = -x_wide;
      stage_next.y = -y_wide;
      stage_next.z = HALF_TURN;
    end else begin
      stage_next.x = x_wide;
      stage_next.y = y_wide;
      stage_next.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (sample.ready) begin
      dn_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dn_data <= stage_next;
    end
  end

endmodule

`default_nettype wire

### src/dsa_cell.sv
// One vectoring CORDIC micro-rotation with its own pipeline register.
// Depends on dsa_pkg; shift amount and table angle come in as tied constants.
`default_nettype none

module dsa_cell import dsa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [SHIFT_W-1:0] shift_amt,
  input  logic [Z_W-1:0]     atan_step,
  input  logic               up_valid,
  output logic               up_ready,
  input  dsa_stage_t         up_data,
  output logic               dn_valid,
  input  logic               dn_ready,
  output dsa_stage_t         dn_data
);

  logic signed [DATA_W-1:0] x_shr, y_shr;
  dsa_stage_t               stage_next;

  assign up_ready = !dn_valid || dn_ready;

  always_comb begin
    x_shr = up_data.x >>> shift_amt;
    y_shr = up_data.y >>> shift_amt;
    stage_next.zero = up_data.zero;
    // A zero residual counts as non-negative and rotates clockwise.
    if (!up_data.y[DATA_W-1]) begin
      stage_next.x = up_data.x + y_shr;
      stage_next.y = up_data.y - x_shr;
      stage_next.z = up_data.z + atan_step;
    end else begin
      stage_next.x = up_data.x - y_shr;
      stage_next.y = up_data.y + x_shr;
      stage_next.z = up_data.z - atan_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_data <= stage_next;
    end
  end

endmodule

`default_nettype wire

### src/dsa_round.sv
// Output stage: rounds the turn accumulator to the angle width and holds the
// result for the consumer. Depends on dsa_pkg and dsa_out_if.
`default_nettype none

module dsa_round import dsa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       up_valid,
  output logic       up_ready,
  input  dsa_stage_t up_data,
  dsa_out_if.source  result
);

  logic [Z_W-1:0]         z_round;
  logic [ANGLE_BITS-1:0]  angle_full;
  logic [ANGLE_OUT_W-1:0] angle_next;

  assign up_ready = !result.valid || result.ready;

  assign z_round    = up_data.z + ROUND_ADD;
  assign angle_full = z_round[Z_W-1 -: ANGLE_BITS];

  generate
    if (ANGLE_BITS >= ANGLE_OUT_W) begin : g_trunc
      assign angle_next = angle_full[ANGLE_OUT_W-1:0];
    end else begin : g_ext
      assign angle_next = {{(ANGLE_OUT_W-ANGLE_BITS){1'b0}}, angle_full};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (up_ready) begin
      result.valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      result.angle_turn <= up_data.zero ? '0 : angle_next;
      result.zero_field <= up_data.zero;
    end
  end

endmodule

`default_nettype wire

### src/differential_sincos_to_angle_core.sv
// Top level of the differential sine/cosine to angle converter.
// Depends on dsa_pkg, dsa_if, dsa_pre, dsa_cell and dsa_round.
//
// The block takes one request of four signed sensor channel codes, forms
// sine = ch0 - ch3 and cosine = ch1 - ch2, and returns atan2(sine, cosine) as
// an unsigned fraction of a full turn (65536 equals 2*pi), rounded half up.
// When both differences are zero the angle is 0 and zero_field is set. The
// arctangent comes from a vectoring CORDIC built as a chain of identical
// rotation cells, one register per cell, so a new request is accepted on
// every clock cycle and one result leaves per cycle while the output is not
// stalled. An accepted request passes through the difference and half-plane
// fold register, one register per rotation cell, and the rounding stage
// into the output register. Every stage keeps its own valid bit and only
// stops when the stage after it is full and stalled, so empty slots in the
// chain are filled while the consumer holds off, and requests are still
// taken while a finished result waits at the output. The block has no
// configuration and no state between requests.
`default_nettype none

module differential_sincos_to_angle_core import dsa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  dsa_in_if.sink    sample,
  dsa_out_if.source result
);

  dsa_stage_t chain_data  [STAGE_COUNT+1];
  logic       chain_valid [STAGE_COUNT+1];
  logic       chain_ready [STAGE_COUNT+1];

  // Difference, zero detection and fold into the right half plane.
  dsa_pre u_pre (
    .clk      (clk),
    .rst      (rst),
    .sample   (sample),
    .dn_valid (chain_valid[0]),
    .dn_ready (chain_ready[0]),
    .dn_data  (chain_data[0])
  );

  // Rotation cell k shifts by k and adds or subtracts atan(2^-k).
  generate
    for (genvar k = 0; k < STAGE_COUNT; k++) begin : g_cell
      dsa_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .shift_amt (SHIFT_W'(k)),
        .atan_step (ATAN_TURN[k]),
        .up_valid  (chain_valid[k]),
        .up_ready  (chain_ready[k]),
        .up_data   (chain_data[k]),
        .dn_valid  (chain_valid[k+1]),
        .dn_ready  (chain_ready[k+1]),
        .dn_data   (chain_data[k+1])
      );
    end
  endgenerate

  // Rounding to the angle width and the output register.
  dsa_round u_round (
    .clk      (clk),
    .rst      (rst),
    .up_valid (chain_valid[STAGE_COUNT]),
    .up_ready (chain_ready[STAGE_COUNT]),
    .up_data  (chain_data[STAGE_COUNT]),
    .result   (result)
  );

endmodule

`default_nettype wire
